@@ sv/hbw_pkg.sv @@
// shared types, constants and codes for the heartbeat watchdog
package hbw_pkg;

    localparam int CHAN_COUNT  = 32;
    localparam int CH_BITS     = $clog2(CHAN_COUNT);
    localparam int CNT_BITS    = CH_BITS + 1;
    localparam int TIME_BITS   = 40;
    localparam int PERIOD_BITS = 30;
    localparam int ACT_BITS    = 6;
    localparam int ADDR_BITS   = 3;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(1000000);
    localparam logic [ACT_BITS-1:0]    ACTIVE_RESET = ACT_BITS'(32);

    // register index, taken from paddr[2]
    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    // command codes
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_SERVICE = 2'd1;
    localparam logic [1:0] CMD_LOAD    = 2'd2;

    typedef struct packed {
        logic [1:0]           command;
        logic [31:0]          levels;
        logic                 enable;
        logic [4:0]           channel;
        logic [TIME_BITS-1:0] timeout_ns;
    } in_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] expired_mask;
    } out_t;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] period_ns;
        logic [CNT_BITS-1:0]    n_mon;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

@@ sv/hbw_ram.sv @@
// simple dual-port ram, one write and one registered read per cycle
module hbw_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 40
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/hbw_regs.sv @@
// apb configuration registers: tick period and monitored channel count
module hbw_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hbw_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output hbw_pkg::cfg_t                cfg
);
    import hbw_pkg::*;

    logic [PERIOD_BITS-1:0] period_reg;
    logic [ACT_BITS-1:0]    active_reg;
    logic                   wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            active_reg <= ACTIVE_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_PERIOD) begin
                period_reg <= pwdata[PERIOD_BITS-1:0];
            end else begin
                active_reg <= pwdata[ACT_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ACTIVE) begin
            prdata = {{(32-ACT_BITS){1'b0}}, active_reg};
        end else begin
            prdata = {{(32-PERIOD_BITS){1'b0}}, period_reg};
        end
    end

    // monitored count saturates at the channel count
    always_comb begin
        cfg.period_ns = period_reg;
        if (active_reg > ACT_BITS'(CHAN_COUNT)) begin
            cfg.n_mon = CNT_BITS'(CHAN_COUNT);
        end else begin
            cfg.n_mon = CNT_BITS'(active_reg);
        end
    end

endmodule

@@ sv/hbw_ctrl.sv @@
// command sequencer: sweeps the channel memories one entry per cycle
module hbw_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  hbw_pkg::cfg_t cfg,
    input  logic          s_valid,
    output logic          s_ready,
    input  hbw_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output hbw_pkg::out_t m_payload
);
    import hbw_pkg::*;

    state_t state_reg, state_next;

    logic                  accept;
    logic                  start_sweep;
    logic                  tick_run;
    logic                  svc_run;
    logic                  last_issue;
    logic                  rd_en;
    logic                  out_load;

    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  rd_vld_reg;
    logic [CH_BITS-1:0]    rd_idx_reg;
    logic                  tick_mode_reg;
    logic [31:0]           levels_reg;
    logic [31:0]           expired_reg;
    logic                  ok_reg;
    logic                  prev_en_reg;
    logic [CHAN_COUNT-1:0] last_level_reg;
    logic [CHAN_COUNT-1:0] rem_vld_reg;
    logic [CHAN_COUNT-1:0] rel_vld_reg;
    logic                  rem_vq_reg;
    logic                  rel_vq_reg;
    logic                  m_valid_reg;
    out_t                  m_payload_reg;

    logic [TIME_BITS-1:0]  rem_rdata, rel_rdata;
    logic [TIME_BITS-1:0]  rem_cur, rel_cur, period_ext, rem_new;
    logic                  rel_we;
    logic                  lvl, changed, under, exp_hit;

    assign accept   = s_valid && s_ready;
    assign tick_run = (s_payload.command == CMD_TICK) && s_payload.enable && ok_reg;
    assign svc_run  = (s_payload.command == CMD_SERVICE) && !ok_reg
                      && s_payload.enable && !prev_en_reg;
    assign start_sweep = (tick_run || svc_run) && (cfg.n_mon != '0);
    assign last_issue  = (cnt_reg + CNT_BITS'(1)) == cfg.n_mon;
    assign rel_we      = accept && (s_payload.command == CMD_LOAD);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = start_sweep ? ST_SWEEP : ST_FINISH;
                end
            end
            ST_SWEEP: begin
                if (last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SWEEP: begin
                rd_en = 1'b1;
            end
            ST_FINISH: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    hbw_ram #(.DEPTH(CHAN_COUNT), .WIDTH(TIME_BITS)) u_rem_ram (
        .aclk  (aclk),
        .we    (rd_vld_reg),
        .waddr (rd_idx_reg),
        .wdata (rem_new),
        .re    (rd_en),
        .raddr (cnt_reg[CH_BITS-1:0]),
        .rdata (rem_rdata)
    );

    hbw_ram #(.DEPTH(CHAN_COUNT), .WIDTH(TIME_BITS)) u_rel_ram (
        .aclk  (aclk),
        .we    (rel_we),
        .waddr (s_payload.channel),
        .wdata (s_payload.timeout_ns),
        .re    (rd_en),
        .raddr (cnt_reg[CH_BITS-1:0]),
        .rdata (rel_rdata)
    );

    // entries never written read as zero
    assign rem_cur    = rem_vq_reg ? rem_rdata : '0;
    assign rel_cur    = rel_vq_reg ? rel_rdata : '0;
    assign period_ext = TIME_BITS'(cfg.period_ns);
    assign lvl        = levels_reg[rd_idx_reg];
    assign changed    = lvl != last_level_reg[rd_idx_reg];
    assign under      = period_ext > rem_cur;
    assign exp_hit    = tick_mode_reg && !changed && under;

    always_comb begin
        if (!tick_mode_reg || changed) begin
            rem_new = rel_cur;
        end else if (under) begin
            rem_new = '0;
        end else begin
            rem_new = rem_cur - period_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            ok_reg         <= 1'b0;
            prev_en_reg    <= 1'b0;
            last_level_reg <= '0;
            rem_vld_reg    <= '0;
            rel_vld_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            if (rd_en) begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end else if (state_reg == ST_IDLE) begin
                cnt_reg <= '0;
            end
            if (accept && (s_payload.command == CMD_SERVICE)) begin
                prev_en_reg <= s_payload.enable;
                if (svc_run) begin
                    ok_reg <= 1'b1;
                end
            end
            if (rel_we) begin
                rel_vld_reg[s_payload.channel] <= 1'b1;
            end
            if (rd_vld_reg) begin
                rem_vld_reg[rd_idx_reg] <= 1'b1;
                if (tick_mode_reg) begin
                    last_level_reg[rd_idx_reg] <= lvl;
                end
                if (exp_hit) begin
                    ok_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg[CH_BITS-1:0];
        rem_vq_reg <= rem_vld_reg[cnt_reg[CH_BITS-1:0]];
        rel_vq_reg <= rel_vld_reg[cnt_reg[CH_BITS-1:0]];
        if (accept) begin
            tick_mode_reg <= s_payload.command == CMD_TICK;
            levels_reg    <= s_payload.levels;
            expired_reg   <= '0;
        end else if (rd_vld_reg && exp_hit) begin
            expired_reg[rd_idx_reg] <= 1'b1;
        end
        if (out_load) begin
            m_payload_reg.ok           <= ok_reg;
            m_payload_reg.expired_mask <= expired_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

@@ sv/multi_input_heartbeat_watchdog.sv @@
// Multi-channel heartbeat watchdog, top level.
//
// Input channel s_*: one command per transfer (tick, service, load timeout).
// Result channel m_*: exactly one result per command, the ok flag after the
// command and the mask of channels that ran out during a tick.
// APB port: period_ns at 0x0, active_inputs at 0x4, write only while idle.
//
// Flow: a load, a skipped tick or a service that re-arms nothing goes
// straight to the finish state, as does any command with no channel
// monitored. A running tick or a re-arming service walks the monitored
// channels (n, 1 to 32) through the time memories, one channel per cycle,
// then passes the drain and finish states before its result is loaded. The
// single read port of each memory sets this pace. One command is in flight
// at a time; s_ready returns once the result sits in the output register,
// so a new command can be taken while the result still waits for
// m_ready.
// Reset: all times, levels and the ok flag read as zero, period is 1 ms and
// all 32 channels are monitored; ok needs a service with a rising enable.
// A stalled receiver holds the result and blocks the next command's finish.
module multi_input_heartbeat_watchdog (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  hbw_pkg::in_t                  s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hbw_pkg::out_t                 m_payload,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hbw_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import hbw_pkg::*;

    cfg_t cfg;

    hbw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hbw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ sv/hbw_checker.sv @@
// port-level checks for the heartbeat watchdog, bound to the top level
module hbw_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input hbw_pkg::out_t m_payload
);
    import hbw_pkg::*;

    // any run-out latches ok low in the same result
    a_expired_clears_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.expired_mask != '0) |-> !m_payload.ok)
        else $error("expired channel reported with ok high");

    // one command in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command taken before the first finished");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed");

endmodule

bind multi_input_heartbeat_watchdog hbw_checker u_hbw_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
